// ----- src/ycfd_pkg.sv -----
`default_nettype none
package ycfd_pkg;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_J        = 3'd0,
        MODE_E        = 3'd1,
        MODE_H        = 3'd2,
        MODE_JDOTE    = 3'd3,
        MODE_POYNTING = 3'd4,
        MODE_ESQ      = 3'd5,
        MODE_HSQ      = 3'd6,
        MODE_NONE     = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_X_ACTIVE = 3'd1,
        REG_Y_ACTIVE = 3'd2,
        REG_Z_ACTIVE = 3'd3,
        REG_X_COUNT  = 3'd4,
        REG_Y_COUNT  = 3'd5,
        REG_Z_COUNT  = 3'd6,
        REG_SPARE    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] e_x;
        logic signed [DATA_W-1:0] e_y;
        logic signed [DATA_W-1:0] e_z;
        logic signed [DATA_W-1:0] h_x;
        logic signed [DATA_W-1:0] h_y;
        logic signed [DATA_W-1:0] h_z;
        logic signed [DATA_W-1:0] cur_x;
        logic signed [DATA_W-1:0] cur_y;
        logic signed [DATA_W-1:0] cur_z;
    } point_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] comp_x;
        logic signed [DATA_W-1:0] comp_y;
        logic signed [DATA_W-1:0] comp_z;
        logic                     clipped;
        logic                     last_cell;
    } result_t;

    // Rounded average of two: (a + b + 1) >> 1, floor shift.
    function automatic logic signed [DATA_W-1:0] avg2(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W+1:0] s;
        s = 34'(a) + 34'(b) + 34'sd1;
        return s[DATA_W:1];
    endfunction

    function automatic logic signed [DATA_W-1:0] avg4(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic signed [DATA_W-1:0] c,
        input logic signed [DATA_W-1:0] d
    );
        logic signed [DATA_W+2:0] s;
        s = 35'(a) + 35'(b) + 35'(c) + 35'(d) + 35'sd2;
        return s[DATA_W+1:2];
    endfunction
endpackage
`default_nettype wire

// ----- src/ycfd_stream_if.sv -----
`default_nettype none
interface ycfd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/yee_cell_center_field_diagnostics.sv -----
`default_nettype none
// Cell-centre field diagnostics on a staggered grid, one grid point per cycle
// while the output queue and the points in flight leave room for it.
// Throughput: one point per cycle while in_ch.ready is high; the plane and row memories
// are read in stage 0 and forwarded, and an eight-entry skid queue absorbs output stalls.
// Reset clears the position, the registers and the pipeline; the buffer memories
// are not cleared, and raster order never reads an unwritten entry into a result.
module yee_cell_center_field_diagnostics
    import ycfd_pkg::*;
#(
    parameter int X_MAX     = 128,
    parameter int Y_MAX     = 128,
    parameter int FRAC_BITS = 16
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    ycfd_stream_if.sink              in_ch,
    ycfd_stream_if.source            out_ch,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [12:0]         cfg_data
);
    localparam int XW    = $clog2(X_MAX);
    localparam int YW    = $clog2(Y_MAX);
    localparam int PW    = XW + YW;
    localparam int PLANE = 1 << PW;
    localparam int QD    = 8;
    localparam int QW    = 3;

    // ---------------- configuration ----------------
    mode_t       mode_reg;
    logic        xa_reg, ya_reg, za_reg;
    logic [7:0]  xcnt_reg, ycnt_reg;
    logic [12:0] zcnt_reg;
    logic        geo_wr;

    assign geo_wr = cfg_we && (reg_idx_t'(cfg_index) != REG_MODE)
                    && (reg_idx_t'(cfg_index) != REG_SPARE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_J;
            xa_reg   <= 1'b1;
            ya_reg   <= 1'b1;
            za_reg   <= 1'b1;
            xcnt_reg <= 8'd128;
            ycnt_reg <= 8'd128;
            zcnt_reg <= 13'd128;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:     mode_reg <= mode_t'(cfg_data[2:0]);
                REG_X_ACTIVE: xa_reg   <= cfg_data[0];
                REG_Y_ACTIVE: ya_reg   <= cfg_data[0];
                REG_Z_ACTIVE: za_reg   <= cfg_data[0];
                REG_X_COUNT:  xcnt_reg <= cfg_data[7:0];
                REG_Y_COUNT:  ycnt_reg <= cfg_data[7:0];
                REG_Z_COUNT:  zcnt_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Effective extents: zero counts as one, x and y saturate at the buffer size.
    logic [XW:0] xc;
    logic [YW:0] yc;
    logic [12:0] zc;
    always_comb
    begin
        if (xcnt_reg == 8'd0)
            xc = (XW+1)'(1);
        else if (32'(xcnt_reg) > X_MAX)
            xc = (XW+1)'(X_MAX);
        else
            xc = (XW+1)'(xcnt_reg);
        if (ycnt_reg == 8'd0)
            yc = (YW+1)'(1);
        else if (32'(ycnt_reg) > Y_MAX)
            yc = (YW+1)'(Y_MAX);
        else
            yc = (YW+1)'(ycnt_reg);
        if (zcnt_reg == 13'd0)
            zc = 13'd1;
        else if (zcnt_reg == 13'd8191)
            zc = 13'd8191;
        else
            zc = zcnt_reg;
    end

    // ---------------- stage 0: accept, position, memory reads ----------------
    logic        acc;
    logic [QW:0] q_cnt_reg;
    logic [2:0]  inflight;

    logic [XW:0] xp_reg;
    logic [YW:0] yp_reg;
    logic [12:0] zp_reg;
    logic [XW:0] xp;
    logic [YW:0] yp;
    logic [12:0] zp;
    logic        wrapall;

    assign wrapall = (xp_reg >= xc) || (yp_reg >= yc) || (zp_reg >= zc);
    assign xp = wrapall ? '0 : xp_reg;
    assign yp = wrapall ? '0 : yp_reg;
    assign zp = wrapall ? '0 : zp_reg;

    logic [XW-1:0] xi;
    logic [YW-1:0] yi;
    logic [PW-1:0] pi, pu;
    assign xi = xp[XW-1:0];
    assign yi = yp[YW-1:0];
    assign pi = {yi, xi};
    assign pu = (yi != '0) ? {yi - YW'(1), xi} : pi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xp_reg <= '0;
            yp_reg <= '0;
            zp_reg <= '0;
        end
        else if (geo_wr)
        begin
            xp_reg <= '0;
            yp_reg <= '0;
            zp_reg <= '0;
        end
        else if (acc)
        begin
            if (xp + 1'b1 >= xc)
            begin
                xp_reg <= '0;
                if (yp + 1'b1 >= yc)
                begin
                    yp_reg <= '0;
                    zp_reg <= (zp + 13'd1 >= zc) ? 13'd0 : zp + 13'd1;
                end
                else
                begin
                    yp_reg <= yp + 1'b1;
                    zp_reg <= zp;
                end
            end
            else
            begin
                xp_reg <= xp + 1'b1;
                yp_reg <= yp;
                zp_reg <= zp;
            end
        end
    end

    // Memories: plane buffers (read at pi and pu) and row buffers.
    logic signed [31:0] pl_ez [PLANE];
    logic signed [31:0] pl_jz [PLANE];
    logic signed [31:0] pl_hy [PLANE];
    logic signed [31:0] pl_hx [PLANE];
    logic signed [31:0] pl_hxu [PLANE];
    logic signed [31:0] rw_hx [X_MAX];
    logic signed [31:0] rw_hz [X_MAX];
    logic signed [31:0] rw_ey [X_MAX];
    logic signed [31:0] rw_jy [X_MAX];

    logic signed [31:0] m_ez, m_jz, m_hy, m_hx, m_hxu, m_rhx, m_rhz, m_rey, m_rjy;

    // Write side, in the cycle after the read (stage 1).
    logic          s1_v_reg;
    point_t        s1_pt_reg;
    logic [PW-1:0] s1_pi_reg;
    logic [XW-1:0] s1_x_reg;
    logic          s1_ghost_reg, s1_last_reg;

    always_ff @(posedge clk)
    begin
        m_ez  <= pl_ez[pi];
        m_jz  <= pl_jz[pi];
        m_hy  <= pl_hy[pi];
        m_hx  <= pl_hx[pi];
        m_hxu <= pl_hxu[pu];
        m_rhx <= rw_hx[xi];
        m_rhz <= rw_hz[xi];
        m_rey <= rw_ey[xi];
        m_rjy <= rw_jy[xi];
    end

    // Forwarded (read-after-write corrected) reads for stage 1.
    logic          s1_fw_pi, s1_fw_pu, s1_fw_x;
    logic signed [31:0] f_ez, f_jz, f_hy, f_hx, f_hxu, f_rhx, f_rhz, f_rey, f_rjy;
    logic signed [31:0] f_ez_reg, f_jz_reg, f_hy_reg, f_hx_reg, f_hxu_reg;
    logic signed [31:0] f_rhx_reg, f_rhz_reg, f_rey_reg, f_rjy_reg;
    logic          fw_pi_reg, fw_pu_reg, fw_x_reg;

    // A read at stage 0 of the entry that stage 1 writes this cycle sees the new value.
    assign s1_fw_pi = s1_v_reg && (s1_pi_reg == pi);
    assign s1_fw_pu = s1_v_reg && (s1_pi_reg == pu);
    assign s1_fw_x  = s1_v_reg && (s1_x_reg == xi);

    logic signed [31:0] wr_rhx;
    assign f_ez  = fw_pi_reg ? f_ez_reg  : m_ez;
    assign f_jz  = fw_pi_reg ? f_jz_reg  : m_jz;
    assign f_hy  = fw_pi_reg ? f_hy_reg  : m_hy;
    assign f_hx  = fw_pi_reg ? f_hx_reg  : m_hx;
    assign f_hxu = fw_pu_reg ? f_hxu_reg : m_hxu;
    assign f_rhx = fw_x_reg  ? f_rhx_reg : m_rhx;
    assign f_rhz = fw_x_reg  ? f_rhz_reg : m_rhz;
    assign f_rey = fw_x_reg  ? f_rey_reg : m_rey;
    assign f_rjy = fw_x_reg  ? f_rjy_reg : m_rjy;
    assign wr_rhx = f_hx;

    always_ff @(posedge clk)
    begin
        fw_pi_reg <= s1_fw_pi && acc;
        fw_pu_reg <= s1_fw_pu && acc;
        fw_x_reg  <= s1_fw_x && acc;
        f_ez_reg  <= s1_pt_reg.e_z;
        f_jz_reg  <= s1_pt_reg.cur_z;
        f_hy_reg  <= s1_pt_reg.h_y;
        f_hx_reg  <= s1_pt_reg.h_x;
        f_hxu_reg <= s1_pt_reg.h_x;
        f_rhx_reg <= wr_rhx;
        f_rhz_reg <= s1_pt_reg.h_z;
        f_rey_reg <= s1_pt_reg.e_y;
        f_rjy_reg <= s1_pt_reg.cur_y;
        if (s1_v_reg)
        begin
            pl_ez[s1_pi_reg]  <= s1_pt_reg.e_z;
            pl_jz[s1_pi_reg]  <= s1_pt_reg.cur_z;
            pl_hy[s1_pi_reg]  <= s1_pt_reg.h_y;
            pl_hx[s1_pi_reg]  <= s1_pt_reg.h_x;
            pl_hxu[s1_pi_reg] <= s1_pt_reg.h_x;
            rw_hx[s1_x_reg]   <= wr_rhx;
            rw_hz[s1_x_reg]   <= s1_pt_reg.h_z;
            rw_ey[s1_x_reg]   <= s1_pt_reg.e_y;
            rw_jy[s1_x_reg]   <= s1_pt_reg.cur_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pt_reg    <= in_ch.payload;
            s1_pi_reg    <= pi;
            s1_x_reg     <= xi;
            s1_ghost_reg <= (xa_reg && xp == '0) || (ya_reg && yp == '0)
                            || (za_reg && zp == '0);
            s1_last_reg  <= (xp == xc - 1'b1) && (yp == yc - 1'b1)
                            && (zp == zc - 13'd1);
        end
    end

    // ---------------- stage 1: averages, previous-point registers ----------------
    logic signed [31:0] pex_reg, pjx_reg, phy_reg, phz_reg, phyb_reg, phzb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pex_reg  <= '0;
            pjx_reg  <= '0;
            phy_reg  <= '0;
            phz_reg  <= '0;
            phyb_reg <= '0;
            phzb_reg <= '0;
        end
        else if (s1_v_reg)
        begin
            pex_reg  <= s1_pt_reg.e_x;
            pjx_reg  <= s1_pt_reg.cur_x;
            phy_reg  <= s1_pt_reg.h_y;
            phz_reg  <= s1_pt_reg.h_z;
            phyb_reg <= f_hy;
            phzb_reg <= f_rhz;
        end
    end

    point_t p1;
    logic signed [31:0] cex, cey, cez, cjx, cjy, cjz, chx, chy, chz;
    logic signed [31:0] hx2, hx3, hy2, hy3, hz2, hz3, hxb, hyb, hzb;
    always_comb
    begin
        p1  = s1_pt_reg;
        cex = avg2(p1.e_x, xa_reg ? pex_reg : p1.e_x);
        cey = avg2(p1.e_y, ya_reg ? f_rey : p1.e_y);
        cez = avg2(p1.e_z, za_reg ? f_ez : p1.e_z);
        cjx = avg2(p1.cur_x, xa_reg ? pjx_reg : p1.cur_x);
        cjy = avg2(p1.cur_y, ya_reg ? f_rjy : p1.cur_y);
        cjz = avg2(p1.cur_z, za_reg ? f_jz : p1.cur_z);
        hx2 = ya_reg ? f_hxu : p1.h_x;
        hxb = za_reg ? f_hx : p1.h_x;
        hx3 = (ya_reg && za_reg) ? f_rhx : ya_reg ? f_hxu : hxb;
        chx = avg4(p1.h_x, hx2, hxb, hx3);
        hy2 = xa_reg ? phy_reg : p1.h_y;
        hyb = za_reg ? f_hy : p1.h_y;
        hy3 = (xa_reg && za_reg) ? phyb_reg : xa_reg ? phy_reg : hyb;
        chy = avg4(p1.h_y, hy2, hyb, hy3);
        hz2 = xa_reg ? phz_reg : p1.h_z;
        hzb = ya_reg ? f_rhz : p1.h_z;
        hz3 = (xa_reg && ya_reg) ? phzb_reg : xa_reg ? phz_reg : hzb;
        chz = avg4(p1.h_z, hz2, hzb, hz3);
    end

    // stage 2 registers: cell-centred values of an interior point
    logic               s2_v_reg, s3_v_reg, s4_v_reg;
    logic               s2_last_reg, s3_last_reg;
    logic signed [31:0] s2_ex, s2_ey, s2_ez, s2_jx, s2_jy, s2_jz, s2_hx, s2_hy, s2_hz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_v_reg && !s1_ghost_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg <= s1_last_reg;
        s2_ex <= cex; s2_ey <= cey; s2_ez <= cez;
        s2_jx <= cjx; s2_jy <= cjy; s2_jz <= cjz;
        s2_hx <= chx; s2_hy <= chy; s2_hz <= chz;
    end

    // ---------------- stage 2: products ----------------
    logic signed [31:0] ma [6];
    logic signed [31:0] mb [6];
    always_comb
    begin
        unique case (mode_reg)
            MODE_JDOTE:
            begin
                ma = '{s2_jx, s2_jy, s2_jz, 32'sd0, 32'sd0, 32'sd0};
                mb = '{s2_ex, s2_ey, s2_ez, 32'sd0, 32'sd0, 32'sd0};
            end
            MODE_POYNTING:
            begin
                ma = '{s2_ey, s2_ez, s2_ex, s2_ez, s2_ex, s2_ey};
                mb = '{s2_hz, s2_hx, s2_hy, s2_hy, s2_hz, s2_hx};
            end
            MODE_ESQ:
            begin
                ma = '{s2_ex, s2_ey, s2_ez, 32'sd0, 32'sd0, 32'sd0};
                mb = '{s2_ex, s2_ey, s2_ez, 32'sd0, 32'sd0, 32'sd0};
            end
            MODE_HSQ:
            begin
                ma = '{s2_hx, s2_hy, s2_hz, 32'sd0, 32'sd0, 32'sd0};
                mb = '{s2_hx, s2_hy, s2_hz, 32'sd0, 32'sd0, 32'sd0};
            end
            MODE_J:
            begin
                ma = '{s2_jx, s2_jy, s2_jz, 32'sd0, 32'sd0, 32'sd0};
                mb = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
            end
            MODE_E:
            begin
                ma = '{s2_ex, s2_ey, s2_ez, 32'sd0, 32'sd0, 32'sd0};
                mb = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
            end
            MODE_H:
            begin
                ma = '{s2_hx, s2_hy, s2_hz, 32'sd0, 32'sd0, 32'sd0};
                mb = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
            end
            default:
            begin
                ma = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
                mb = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
            end
        endcase
    end

    logic signed [63:0] prod_reg [6];
    logic signed [31:0] pass_reg [3];
    always_ff @(posedge clk)
    begin
        s3_last_reg <= s2_last_reg;
        for (int i = 0; i < 6; i++)
            prod_reg[i] <= ma[i] * mb[i];
        for (int i = 0; i < 3; i++)
            pass_reg[i] <= ma[i];
    end

    // ---------------- stage 3: difference, round, saturate ----------------
    logic signed [64:0] diff [3];
    logic signed [64:0] rnd [3];
    logic signed [64:0] shf [3];
    logic signed [31:0] res [3];
    logic               clp [3];
    logic               is_prod;
    localparam logic signed [64:0] HALF = (FRAC_BITS == 0) ? 65'sd0
                                          : (65'sd1 <<< (FRAC_BITS - 1));
    always_comb
    begin
        is_prod = (mode_reg == MODE_JDOTE) || (mode_reg == MODE_POYNTING)
                  || (mode_reg == MODE_ESQ) || (mode_reg == MODE_HSQ);
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = (mode_reg == MODE_POYNTING)
                      ? 65'(prod_reg[i]) - 65'(prod_reg[i+3]) : 65'(prod_reg[i]);
            rnd[i]  = diff[i] + HALF;
            shf[i]  = rnd[i] >>> FRAC_BITS;
            if (!is_prod)
            begin
                res[i] = pass_reg[i];
                clp[i] = 1'b0;
            end
            else if (shf[i] > 65'sd2147483647)
            begin
                res[i] = 32'sh7fffffff;
                clp[i] = 1'b1;
            end
            else if (shf[i] < -65'sd2147483648)
            begin
                res[i] = 32'sh80000000;
                clp[i] = 1'b1;
            end
            else
            begin
                res[i] = shf[i][31:0];
                clp[i] = 1'b0;
            end
        end
    end

    result_t s4_res_reg;
    always_ff @(posedge clk)
    begin
        s4_res_reg.comp_x    <= res[0];
        s4_res_reg.comp_y    <= res[1];
        s4_res_reg.comp_z    <= res[2];
        s4_res_reg.clipped   <= clp[0] | clp[1] | clp[2];
        s4_res_reg.last_cell <= s3_last_reg;
    end

    // ---------------- output queue ----------------
    // Items in flight are credited against queue space, so the queue never overflows.
    result_t       q_mem [QD];
    logic [QW-1:0] q_wp_reg, q_rp_reg;
    logic          q_push, q_pop;

    assign inflight = 3'(s1_v_reg) + 3'(s2_v_reg) + 3'(s3_v_reg) + 3'(s4_v_reg);
    assign in_ch.ready = (32'(q_cnt_reg) + 32'(inflight)) < QD;
    assign acc = in_ch.valid && in_ch.ready;

    assign q_push = s4_v_reg;
    assign q_pop  = out_ch.valid && out_ch.ready;
    assign out_ch.valid   = (q_cnt_reg != '0);
    assign out_ch.payload = q_mem[q_rp_reg];

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_wp_reg] <= s4_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= '0;
            q_rp_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
                q_wp_reg <= q_wp_reg + 1'b1;
            if (q_pop)
                q_rp_reg <= q_rp_reg + 1'b1;
            q_cnt_reg <= q_cnt_reg + (QW+1)'(q_push) - (QW+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

// ----- verif/tb_yee_cell_center_field_diagnostics.sv -----
`default_nettype none
module tb_yee_cell_center_field_diagnostics;
    import ycfd_pkg::*;

    localparam int FRAC        = 16;
    localparam int ROW_LEN     = 128;
    localparam int COL_LEN     = 128;
    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 600000;

    // Predicts the cell-centred quantity for every interior grid point and
    // keeps the results still owed by the block.
    class cell_center_board;
        mode_t       mode;
        bit          x_act, y_act, z_act;
        int unsigned x_cnt, y_cnt, z_cnt;
        int unsigned x_pos, y_pos, z_pos;
        int          pl_hx[ROW_LEN*COL_LEN], pl_hy[ROW_LEN*COL_LEN];
        int          pl_ez[ROW_LEN*COL_LEN], pl_jz[ROW_LEN*COL_LEN];
        int          rw_hx[ROW_LEN], rw_hz[ROW_LEN], rw_ey[ROW_LEN], rw_jy[ROW_LEN];
        int          last_ex, last_jx, last_hy, last_hz, last_hy_below, last_hz_behind;
        result_t     pending_cells[$];
        int          mismatch_count;

        function new();
            mode = MODE_J;
            x_act = 1'b1;
            y_act = 1'b1;
            z_act = 1'b1;
            x_cnt = 128;
            y_cnt = 128;
            z_cnt = 128;
            x_pos = 0;
            y_pos = 0;
            z_pos = 0;
            mismatch_count = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [12:0] v);
            case (idx)
                REG_MODE:     mode = mode_t'(v[2:0]);
                REG_X_ACTIVE: x_act = v[0];
                REG_Y_ACTIVE: y_act = v[0];
                REG_Z_ACTIVE: z_act = v[0];
                REG_X_COUNT:  x_cnt = v[7:0];
                REG_Y_COUNT:  y_cnt = v[7:0];
                REG_Z_COUNT:  z_cnt = v[12:0];
                default:      return;
            endcase
            if (idx != REG_MODE)
            begin
                x_pos = 0;
                y_pos = 0;
                z_pos = 0;
            end
        endfunction

        function int unsigned clamp_count(int unsigned c, int unsigned cap);
            if (c == 0)
                return 1;
            return (c > cap) ? cap : c;
        endfunction

        function longint half_sum(longint a, longint b);
            return (a + b + 1) >>> 1;
        endfunction

        function longint quarter_sum(longint a, longint b, longint c, longint d);
            return (a + b + c + d + 2) >>> 2;
        endfunction

        // a*b - c*d rescaled and saturated; wide enough for the full difference.
        function longint fix_mul_sub(longint a, longint b, longint c, longint d,
                                     inout bit clip);
            logic signed [65:0] aa, bb, cc, dd, v;
            aa = a;
            bb = b;
            cc = c;
            dd = d;
            v = aa * bb - cc * dd;
            v = (v + (66'sd1 <<< (FRAC - 1))) >>> FRAC;
            if (v > 66'sd2147483647)
            begin
                clip = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -66'sd2147483648)
            begin
                clip = 1'b1;
                return -64'sd2147483648;
            end
            return longint'(v);
        endfunction

        function void take_point(point_t p);
            longint ex, ey, ez, hx, hy, hz, jx, jy, jz;
            longint ez_b, jz_b, hx_b, hy_b, hx_u, hx_ub, ey_u, jy_u, hz_u;
            longint cex, cey, cez, cjx, cjy, cjz, chx, chy, chz;
            longint r[3];
            int unsigned xc, yc, zc, xi, yi, pi, pu;
            bit nx, ny, nz, ghost, is_last, clip;
            result_t res;
            ex = $signed(p.e_x);
            ey = $signed(p.e_y);
            ez = $signed(p.e_z);
            hx = $signed(p.h_x);
            hy = $signed(p.h_y);
            hz = $signed(p.h_z);
            jx = $signed(p.cur_x);
            jy = $signed(p.cur_y);
            jz = $signed(p.cur_z);
            xc = clamp_count(x_cnt, ROW_LEN);
            yc = clamp_count(y_cnt, COL_LEN);
            zc = clamp_count(z_cnt, 8191);
            nx = x_act;
            ny = y_act;
            nz = z_act;
            clip = 1'b0;
            if (x_pos >= xc || y_pos >= yc || z_pos >= zc)
            begin
                x_pos = 0;
                y_pos = 0;
                z_pos = 0;
            end
            xi = x_pos;
            yi = y_pos;
            pi = yi * ROW_LEN + xi;
            pu = (yi > 0) ? (yi - 1) * ROW_LEN + xi : pi;

            ez_b = pl_ez[pi];
            jz_b = pl_jz[pi];
            hx_b = pl_hx[pi];
            hy_b = pl_hy[pi];
            hx_u = pl_hx[pu];
            hx_ub = rw_hx[xi];
            ey_u = rw_ey[xi];
            jy_u = rw_jy[xi];
            hz_u = rw_hz[xi];

            cex = half_sum(ex, nx ? longint'(last_ex) : ex);
            cey = half_sum(ey, ny ? ey_u : ey);
            cez = half_sum(ez, nz ? ez_b : ez);
            cjx = half_sum(jx, nx ? longint'(last_jx) : jx);
            cjy = half_sum(jy, ny ? jy_u : jy);
            cjz = half_sum(jz, nz ? jz_b : jz);
            chx = quarter_sum(hx, ny ? hx_u : hx, nz ? hx_b : hx,
                              (ny && nz) ? hx_ub : ny ? hx_u : nz ? hx_b : hx);
            chy = quarter_sum(hy, nx ? longint'(last_hy) : hy, nz ? hy_b : hy,
                              (nx && nz) ? longint'(last_hy_below) :
                              nx ? longint'(last_hy) : nz ? hy_b : hy);
            chz = quarter_sum(hz, nx ? longint'(last_hz) : hz, ny ? hz_u : hz,
                              (nx && ny) ? longint'(last_hz_behind) :
                              nx ? longint'(last_hz) : ny ? hz_u : hz);

            ghost = (nx && x_pos == 0) || (ny && y_pos == 0) || (nz && z_pos == 0);
            is_last = (x_pos == xc - 1) && (y_pos == yc - 1) && (z_pos == zc - 1);

            rw_hx[xi] = int'(hx_b);
            pl_ez[pi] = int'(ez);
            pl_jz[pi] = int'(jz);
            pl_hx[pi] = int'(hx);
            pl_hy[pi] = int'(hy);
            rw_ey[xi] = int'(ey);
            rw_jy[xi] = int'(jy);
            rw_hz[xi] = int'(hz);
            last_ex = int'(ex);
            last_jx = int'(jx);
            last_hy = int'(hy);
            last_hz = int'(hz);
            last_hy_below = int'(hy_b);
            last_hz_behind = int'(hz_u);

            x_pos++;
            if (x_pos >= xc)
            begin
                x_pos = 0;
                y_pos++;
                if (y_pos >= yc)
                begin
                    y_pos = 0;
                    z_pos++;
                    if (z_pos >= zc)
                        z_pos = 0;
                end
            end

            if (ghost)
                return;

            case (mode)
                MODE_J:
                begin
                    r[0] = cjx;
                    r[1] = cjy;
                    r[2] = cjz;
                end
                MODE_E:
                begin
                    r[0] = cex;
                    r[1] = cey;
                    r[2] = cez;
                end
                MODE_H:
                begin
                    r[0] = chx;
                    r[1] = chy;
                    r[2] = chz;
                end
                MODE_JDOTE:
                begin
                    r[0] = fix_mul_sub(cjx, cex, 0, 0, clip);
                    r[1] = fix_mul_sub(cjy, cey, 0, 0, clip);
                    r[2] = fix_mul_sub(cjz, cez, 0, 0, clip);
                end
                MODE_POYNTING:
                begin
                    r[0] = fix_mul_sub(cey, chz, cez, chy, clip);
                    r[1] = fix_mul_sub(cez, chx, cex, chz, clip);
                    r[2] = fix_mul_sub(cex, chy, cey, chx, clip);
                end
                MODE_ESQ:
                begin
                    r[0] = fix_mul_sub(cex, cex, 0, 0, clip);
                    r[1] = fix_mul_sub(cey, cey, 0, 0, clip);
                    r[2] = fix_mul_sub(cez, cez, 0, 0, clip);
                end
                MODE_HSQ:
                begin
                    r[0] = fix_mul_sub(chx, chx, 0, 0, clip);
                    r[1] = fix_mul_sub(chy, chy, 0, 0, clip);
                    r[2] = fix_mul_sub(chz, chz, 0, 0, clip);
                end
                default:
                begin
                    r[0] = 0;
                    r[1] = 0;
                    r[2] = 0;
                end
            endcase
            res.comp_x = r[0][31:0];
            res.comp_y = r[1][31:0];
            res.comp_z = r[2][31:0];
            res.clipped = clip;
            res.last_cell = is_last;
            pending_cells.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_cells.size() == 0)
            begin
                $error("result beat with nothing expected: %h", got);
                mismatch_count++;
                return;
            end
            want = pending_cells.pop_front();
            if (got.comp_x !== want.comp_x)
            begin
                $error("comp_x: expected %h, got %h", want.comp_x, got.comp_x);
                mismatch_count++;
            end
            if (got.comp_y !== want.comp_y)
            begin
                $error("comp_y: expected %h, got %h", want.comp_y, got.comp_y);
                mismatch_count++;
            end
            if (got.comp_z !== want.comp_z)
            begin
                $error("comp_z: expected %h, got %h", want.comp_z, got.comp_z);
                mismatch_count++;
            end
            if (got.clipped !== want.clipped)
            begin
                $error("clipped: expected %b, got %b", want.clipped, got.clipped);
                mismatch_count++;
            end
            if (got.last_cell !== want.last_cell)
            begin
                $error("last_cell: expected %b, got %b", want.last_cell, got.last_cell);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;

    ycfd_stream_if #(.payload_t(point_t))  in_ch();
    ycfd_stream_if #(.payload_t(result_t)) out_ch();

    yee_cell_center_field_diagnostics u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cell_center_board board = new();
    int  points_sent;
    int  cycle_count;
    bit  quiet;
    bit  hold_req;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.payload);
    end

    // Receiver: random stall bursts, one long hold on request, none near the end.
    initial
    begin
        int hold_left;
        int burst_left;
        hold_left = 0;
        burst_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst_left = $urandom_range(0, 15);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [12:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        board.set_reg(idx, v);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_point(point_t p);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= p;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.take_point(p);
        points_sent++;
    endtask

    // Ghost points give no result, so the wait after the last owed result covers any still in flight.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (board.pending_cells.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic point_t pick_point();
        point_t p;
        p.e_x = pick_word();
        p.e_y = pick_word();
        p.e_z = pick_word();
        p.h_x = pick_word();
        p.h_y = pick_word();
        p.h_z = pick_word();
        p.cur_x = pick_word();
        p.cur_y = pick_word();
        p.cur_z = pick_word();
        return p;
    endfunction

    function automatic logic [12:0] pick_row_count();
        case ($urandom_range(0, 11))
            0:       return 13'd0;
            1:       return 13'd128;
            2:       return 13'd200;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    initial
    begin
        point_t p;
        int     phase;
        int     n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        points_sent = 0;
        cycle_count = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every dimension collapsed: each point is its own cell, so the extremes
        // reach the arithmetic directly, in every mode including the unused one.
        write_reg(REG_X_ACTIVE, 13'd0);
        write_reg(REG_Y_ACTIVE, 13'd0);
        write_reg(REG_Z_ACTIVE, 13'd0);
        write_reg(REG_X_COUNT, 13'd0);
        write_reg(REG_Y_COUNT, 13'd1);
        write_reg(REG_Z_COUNT, 13'd1);
        write_reg(REG_SPARE, 13'h1fff);
        end_writes();
        for (int m = 0; m < 8; m++)
        begin
            write_reg(REG_MODE, 13'(m));
            end_writes();
            p = {9{32'h7fff_ffff}};
            send_point(p);
            p = {9{32'h8000_0000}};
            send_point(p);
            p = pick_point();
            send_point(p);
            drain();
        end

        phase = 0;
        while (points_sent < ITEM_TARGET)
        begin
            write_reg(REG_MODE, 13'($urandom_range(0, 7)));
            write_reg(REG_X_ACTIVE, 13'($urandom_range(0, 3) != 0));
            write_reg(REG_Y_ACTIVE, 13'($urandom_range(0, 3) != 0));
            write_reg(REG_Z_ACTIVE, 13'($urandom_range(0, 3) != 0));
            write_reg(REG_X_COUNT, pick_row_count());
            write_reg(REG_Y_COUNT, ($urandom_range(0, 5) == 0) ? 13'd2 : pick_row_count());
            case ($urandom_range(0, 9))
                0:       write_reg(REG_Z_COUNT, 13'd0);
                1:       write_reg(REG_Z_COUNT, 13'd8191);
                default: write_reg(REG_Z_COUNT, 13'($urandom_range(1, 6)));
            endcase
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, 13'($urandom));
            end_writes();
            if (phase == 3)
                hold_req = 1'b1;
            n = $urandom_range(40, 160);
            for (int i = 0; i < n; i++)
            begin
                if (points_sent > ITEM_TARGET - 300)
                    quiet = 1'b1;
                send_point(pick_point());
            end
            drain();
            phase++;
        end

        if (board.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
